### hdl/bdd_pkg.sv
// Shared types, codes and reset values for the button debounce event detector.
package bdd_pkg;

  // Default width of the debounce, hold and cycle counters.
  localparam int unsigned COUNT_WIDTH_DEF = 8;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEBOUNCE_TICKS     = 3'd0;
  localparam logic [2:0] CFG_LONG_TICKS         = 3'd1;
  localparam logic [2:0] CFG_LONG_REPEAT_TICKS  = 3'd2;
  localparam logic [2:0] CFG_REPEAT_TICKS       = 3'd3;
  localparam logic [2:0] CFG_ACTIVE_LEVEL       = 3'd4;
  localparam logic [2:0] CFG_REPEAT_MODE        = 3'd5;
  localparam logic [2:0] CFG_LONG_ON_RELEASE    = 3'd6;
  localparam logic [2:0] CFG_LONG_HANDLER       = 3'd7;

  // Configuration reset values.
  localparam logic [7:0] RST_DEBOUNCE_TICKS    = 8'd3;
  localparam logic [7:0] RST_LONG_TICKS        = 8'd50;
  localparam logic [7:0] RST_LONG_REPEAT_TICKS = 8'd1;
  localparam logic [7:0] RST_REPEAT_TICKS      = 8'd10;
  localparam logic       RST_ACTIVE_LEVEL      = 1'b0;
  localparam logic       RST_REPEAT_MODE       = 1'b0;
  localparam logic       RST_LONG_ON_RELEASE   = 1'b0;
  localparam logic       RST_LONG_HANDLER      = 1'b1;

  // Press state machine.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DOWN = 2'd1,
    ST_UP   = 2'd2
  } press_state_t;

  // Last event code.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DOWN     = 3'd1,
    EV_UP       = 3'd2,
    EV_LONG     = 3'd3,
    EV_LONG_REL = 3'd4,
    EV_REP      = 3'd5,
    EV_REP_REL  = 3'd6
  } event_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] long_ticks;
    logic [7:0] long_repeat_ticks;
    logic [7:0] repeat_ticks;
    logic       active_level;
    logic       repeat_mode;
    logic       long_on_release_mode;
    logic       long_handler_attached;
  } cfg_t;

  // One-tick event flags of a result.
  typedef struct packed {
    logic release_fired;
    logic click_fired;
    logic long_fired;
    logic long_release_fired;
    logic repeat_fired;
    logic repeat_release_fired;
  } flags_t;

endpackage

### hdl/bdd_step.sv
// Per-tick next-state and event logic of the debounce and press state machine.
module bdd_step #(
  parameter int unsigned COUNT_WIDTH = bdd_pkg::COUNT_WIDTH_DEF
) (
  input  bdd_pkg::cfg_t         cfg,
  input  logic                  level,
  input  logic                  level_valid,
  input  logic                  stable_level,
  input  logic [COUNT_WIDTH-1:0] debounce_count,
  input  logic [COUNT_WIDTH-1:0] hold_count,
  input  logic [COUNT_WIDTH-1:0] cycle_count,
  input  bdd_pkg::press_state_t machine_state,
  input  bdd_pkg::event_t       event_code,
  output logic                  stable_level_nxt,
  output logic [COUNT_WIDTH-1:0] debounce_count_nxt,
  output logic [COUNT_WIDTH-1:0] hold_count_nxt,
  output logic [COUNT_WIDTH-1:0] cycle_count_nxt,
  output bdd_pkg::press_state_t machine_state_nxt,
  output bdd_pkg::event_t       event_code_nxt,
  output bdd_pkg::flags_t       flags
);

  // Counters and 8-bit thresholds are compared at the wider of the two widths.
  localparam int unsigned CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // Sequential update of one tick, in the order the events are checked.
  always_comb begin
    stable_level_nxt   = stable_level;
    debounce_count_nxt = debounce_count;
    hold_count_nxt     = hold_count;
    cycle_count_nxt    = cycle_count;
    machine_state_nxt  = machine_state;
    event_code_nxt     = event_code;
    flags              = '0;

    if (level_valid) begin
      // Debounce: a changed level must persist before it is taken.
      if (level != stable_level) begin
        debounce_count_nxt = debounce_count + CNT_ONE;
        if (CMP_W'(debounce_count_nxt) >= CMP_W'(cfg.debounce_ticks)) begin
          stable_level_nxt   = level;
          debounce_count_nxt = '0;
          hold_count_nxt     = '0;
          cycle_count_nxt    = '0;
          if (level == cfg.active_level) begin
            machine_state_nxt = bdd_pkg::ST_DOWN;
          end else begin
            machine_state_nxt   = bdd_pkg::ST_UP;
            flags.release_fired = 1'b1;
          end
        end
      end else begin
        debounce_count_nxt = '0;
      end

      // Press state machine.
      case (machine_state_nxt)
        bdd_pkg::ST_DOWN: begin
          if (stable_level_nxt == cfg.active_level) begin
            if (cfg.repeat_mode) begin
              cycle_count_nxt = cycle_count_nxt + CNT_ONE;
              if (CMP_W'(cycle_count_nxt) >= CMP_W'(cfg.repeat_ticks)) begin
                cycle_count_nxt    = '0;
                event_code_nxt     = bdd_pkg::EV_REP;
                flags.repeat_fired = 1'b1;
              end
            end else begin
              event_code_nxt = bdd_pkg::EV_DOWN;
              hold_count_nxt = hold_count_nxt + CNT_ONE;
              if (CMP_W'(hold_count_nxt) >= CMP_W'(cfg.long_ticks)) begin
                if (cfg.long_on_release_mode) begin
                  event_code_nxt = bdd_pkg::EV_LONG;
                end else begin
                  cycle_count_nxt = cycle_count_nxt + CNT_ONE;
                  if (CMP_W'(cycle_count_nxt) >= CMP_W'(cfg.long_repeat_ticks)) begin
                    cycle_count_nxt = '0;
                    if (cfg.long_handler_attached) begin
                      event_code_nxt    = bdd_pkg::EV_LONG;
                      flags.long_fired  = 1'b1;
                      machine_state_nxt = bdd_pkg::ST_IDLE;
                    end else begin
                      event_code_nxt = bdd_pkg::EV_DOWN;
                    end
                  end
                end
                // The hold counter saturates back to the long threshold.
                if (hold_count_nxt == CNT_MAX) begin
                  hold_count_nxt = COUNT_WIDTH'(cfg.long_ticks);
                end
              end
            end
          end
        end
        bdd_pkg::ST_UP: begin
          if (event_code_nxt == bdd_pkg::EV_DOWN) begin
            hold_count_nxt    = '0;
            flags.click_fired = 1'b1;
            machine_state_nxt = bdd_pkg::ST_IDLE;
          end else if (event_code_nxt == bdd_pkg::EV_LONG) begin
            if (cfg.long_on_release_mode) begin
              flags.long_fired = 1'b1;
            end else begin
              flags.long_release_fired = 1'b1;
            end
            hold_count_nxt    = '0;
            machine_state_nxt = bdd_pkg::ST_IDLE;
          end else if (cfg.repeat_mode && (event_code_nxt == bdd_pkg::EV_REP)) begin
            hold_count_nxt             = '0;
            flags.repeat_release_fired = 1'b1;
            machine_state_nxt          = bdd_pkg::ST_IDLE;
          end
        end
        default: begin
          hold_count_nxt  = '0;
          cycle_count_nxt = '0;
        end
      endcase
    end
  end

endmodule

### hdl/button_debounce_event_detector_core.sv
// An accepted tick is held in the input register, and its result then in the result register.
// Throughput: one tick per cycle unless stalled; the input register and the result register
// form a two-deep pipeline, so one more tick is taken while a result waits at the output.
// The machine state is updated as a tick moves from the input register to the result register.
// Reset (rst_n low, synchronous): configuration returns to its defaults, the stable level
// to the inverse of the default active level, counters to zero, state idle, event none.
module button_debounce_event_detector_core #(
  parameter int unsigned COUNT_WIDTH = bdd_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Tick input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_level,
  input  logic       in_level_valid,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_release_fired,
  output logic       out_click_fired,
  output logic       out_long_fired,
  output logic       out_long_release_fired,
  output logic       out_repeat_fired,
  output logic       out_repeat_release_fired,
  output logic [1:0] out_press_state,
  output logic [2:0] out_last_event
);

  bdd_pkg::cfg_t         cfg_r;
  logic                  in_valid_r;
  logic                  level_r;
  logic                  level_valid_r;
  logic                  advance;
  logic                  stable_level_r,   stable_level_nxt;
  logic [COUNT_WIDTH-1:0] debounce_count_r, debounce_count_nxt;
  logic [COUNT_WIDTH-1:0] hold_count_r,     hold_count_nxt;
  logic [COUNT_WIDTH-1:0] cycle_count_r,    cycle_count_nxt;
  bdd_pkg::press_state_t machine_state_r,  machine_state_nxt;
  bdd_pkg::event_t       event_code_r,     event_code_nxt;
  bdd_pkg::flags_t       flags_nxt, flags_r;
  logic                  out_valid_r;
  bdd_pkg::press_state_t press_state_r;
  bdd_pkg::event_t       last_event_r;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks        <= bdd_pkg::RST_DEBOUNCE_TICKS;
      cfg_r.long_ticks            <= bdd_pkg::RST_LONG_TICKS;
      cfg_r.long_repeat_ticks     <= bdd_pkg::RST_LONG_REPEAT_TICKS;
      cfg_r.repeat_ticks          <= bdd_pkg::RST_REPEAT_TICKS;
      cfg_r.active_level          <= bdd_pkg::RST_ACTIVE_LEVEL;
      cfg_r.repeat_mode           <= bdd_pkg::RST_REPEAT_MODE;
      cfg_r.long_on_release_mode  <= bdd_pkg::RST_LONG_ON_RELEASE;
      cfg_r.long_handler_attached <= bdd_pkg::RST_LONG_HANDLER;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdd_pkg::CFG_DEBOUNCE_TICKS:    cfg_r.debounce_ticks        <= cfg_data;
        bdd_pkg::CFG_LONG_TICKS:        cfg_r.long_ticks            <= cfg_data;
        bdd_pkg::CFG_LONG_REPEAT_TICKS: cfg_r.long_repeat_ticks     <= cfg_data;
        bdd_pkg::CFG_REPEAT_TICKS:      cfg_r.repeat_ticks          <= cfg_data;
        bdd_pkg::CFG_ACTIVE_LEVEL:      cfg_r.active_level          <= cfg_data[0];
        bdd_pkg::CFG_REPEAT_MODE:       cfg_r.repeat_mode           <= cfg_data[0];
        bdd_pkg::CFG_LONG_ON_RELEASE:   cfg_r.long_on_release_mode  <= cfg_data[0];
        bdd_pkg::CFG_LONG_HANDLER:      cfg_r.long_handler_attached <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A tick moves on when the result register is empty or being drained.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      level_r       <= in_level;
      level_valid_r <= in_level_valid;
    end
  end

  bdd_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .cfg                (cfg_r),
    .level              (level_r),
    .level_valid        (level_valid_r),
    .stable_level       (stable_level_r),
    .debounce_count     (debounce_count_r),
    .hold_count         (hold_count_r),
    .cycle_count        (cycle_count_r),
    .machine_state      (machine_state_r),
    .event_code         (event_code_r),
    .stable_level_nxt   (stable_level_nxt),
    .debounce_count_nxt (debounce_count_nxt),
    .hold_count_nxt     (hold_count_nxt),
    .cycle_count_nxt    (cycle_count_nxt),
    .machine_state_nxt  (machine_state_nxt),
    .event_code_nxt     (event_code_nxt),
    .flags              (flags_nxt)
  );

  // Detector state, updated once per tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_level_r   <= ~bdd_pkg::RST_ACTIVE_LEVEL;
      debounce_count_r <= '0;
      hold_count_r     <= '0;
      cycle_count_r    <= '0;
      machine_state_r  <= bdd_pkg::ST_IDLE;
      event_code_r     <= bdd_pkg::EV_NONE;
    end else if (advance) begin
      stable_level_r   <= stable_level_nxt;
      debounce_count_r <= debounce_count_nxt;
      hold_count_r     <= hold_count_nxt;
      cycle_count_r    <= cycle_count_nxt;
      machine_state_r  <= machine_state_nxt;
      event_code_r     <= event_code_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags_r       <= flags_nxt;
      press_state_r <= machine_state_nxt;
      last_event_r  <= event_code_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_release_fired        = flags_r.release_fired;
  assign out_click_fired          = flags_r.click_fired;
  assign out_long_fired           = flags_r.long_fired;
  assign out_long_release_fired   = flags_r.long_release_fired;
  assign out_repeat_fired         = flags_r.repeat_fired;
  assign out_repeat_release_fired = flags_r.repeat_release_fired;
  assign out_press_state          = press_state_r;
  assign out_last_event           = last_event_r;

  // At most one press event fires per tick; a release may come with any of them.
  a_one_press_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({flags_r.click_fired, flags_r.long_fired,
                              flags_r.long_release_fired, flags_r.repeat_fired,
                              flags_r.repeat_release_fired}))
    else $error("more than one press event in one beat");

  // A click always ends the press cycle.
  a_click_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && flags_r.click_fired) |-> (press_state_r == bdd_pkg::ST_IDLE))
    else $error("click without return to idle");

  // A repeat event leaves the repeat code as the last event.
  a_repeat_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && flags_r.repeat_fired) |-> (last_event_r == bdd_pkg::EV_REP))
    else $error("repeat event with wrong event code");

  // The input side stalls only while both pipeline registers are full and blocked.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule
